FILE: hdl/mdfc_pkg.sv
`default_nettype none

package mdfc_pkg;

   // Table and map sizing
   localparam int TALLY_ENTRIES = 256;
   localparam int MAX_CELLS     = 4096;

   // Field widths
   localparam int DEPTH_W = 24;
   localparam int COUNT_W = 13;
   localparam int CELLS_W = 13;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Depth and count constants
   localparam logic [DEPTH_W-1:0] FAR_DEPTH       = {DEPTH_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX       = {COUNT_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_ONE       = COUNT_W'(1);
   localparam logic [CELLS_W-1:0] CELLS_LIMIT     = CELLS_W'(MAX_CELLS);
   localparam logic [CELLS_W-1:0] MAP_CELLS_RESET = CELLS_W'(4096);

   // Register word index (byte address / 4)
   typedef enum logic {
      REG_MAP_CELLS = 1'b0
   } reg_idx_type;

   // Sample kind
   typedef enum logic {
      ACT_TALLY    = 1'b0,
      ACT_CLASSIFY = 1'b1
   } action_type;

   // Controller state
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_WALK = 1'b1
   } state_type;

   // Token handed from cell to cell, one cell per cycle
   typedef struct packed {
      logic               live;   // a sample occupies this stage
      logic               done;   // matched or inserted further up the chain
      logic               hit;    // done by a match (count is valid)
      logic [DEPTH_W-1:0] depth;
      logic [COUNT_W-1:0] count;
   } tok_type;

endpackage

`default_nettype wire

FILE: hdl/mdfc_cell.sv
`default_nettype none

module mdfc_cell
   import mdfc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    clear,
   input  wire tok_type tok_i,
   output tok_type      tok_o
);

   logic               used_ff,  used_in;
   logic [DEPTH_W-1:0] value_ff, value_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] count_inc;
   tok_type            tok_ff,   tok_in;

   // Saturating repeat count
   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_ONE;

   // Match, insert or pass the token on
   always_comb begin
      used_in  = used_ff;
      value_in = value_ff;
      count_in = count_ff;
      tok_in   = tok_i;
      if (tok_i.live && !tok_i.done) begin
         if (used_ff && (value_ff == tok_i.depth)) begin
            count_in     = count_inc;
            tok_in.done  = 1'b1;
            tok_in.hit   = 1'b1;
            tok_in.count = count_inc;
         end else if (!used_ff) begin
            used_in      = 1'b1;
            value_in     = tok_i.depth;
            count_in     = COUNT_ONE;
            tok_in.done  = 1'b1;
            tok_in.hit   = 1'b0;
            tok_in.count = COUNT_ONE;
         end
      end
      // map start empties the whole table at once
      if (clear) begin
         used_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         tok_ff  <= '0;
      end else begin
         used_ff <= used_in;
         tok_ff  <= tok_in;
      end
   end

   // Entry payload
   always_ff @(posedge clock) begin
      value_ff <= value_in;
      count_ff <= count_in;
   end

   assign tok_o = tok_ff;

endmodule

`default_nettype wire

FILE: hdl/mdfc_ctrl.sv
`default_nettype none

module mdfc_ctrl
   import mdfc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // sample channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_action,
   input  wire logic [DEPTH_W-1:0]    req_depth,
   input  wire logic                  req_first_of_map,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_blocked,
   output logic                       rsp_floor_found,
   output logic [DEPTH_W-1:0]         rsp_floor_depth,
   output logic                       rsp_table_overflow,
   // configuration port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready,
   // cell chain
   output tok_type                    inj_tok,
   output logic                       tbl_clear,
   input  wire tok_type               end_tok
);

   state_type          state_ff, state_in;
   logic [CELLS_W-1:0] map_cells_ff, map_cells_in;
   logic               floor_valid_ff, floor_valid_in;
   logic [DEPTH_W-1:0] floor_level_ff, floor_level_in;
   logic               overflow_ff, overflow_in;
   tok_type            inj_ff, inj_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               blocked_ff, blocked_in;
   logic               found_ff, found_in;
   logic [DEPTH_W-1:0] fdepth_ff, fdepth_in;
   logic               ovf_ff, ovf_in;

   logic               accept, out_free, is_tally, walk_start, walk_end, latch;
   logic               csr_write, load;
   logic [CELLS_W-1:0] cells_eff, thr;
   reg_idx_type        reg_idx;

   // Handshake
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) && out_free);
   assign accept     = req_valid && !req_stall;
   assign is_tally   = (req_action == ACT_TALLY);
   assign tbl_clear  = accept && is_tally && req_first_of_map;
   assign walk_start = accept && is_tally && !floor_valid_ff;
   assign walk_end   = end_tok.live;

   // Majority threshold: half the clamped cell count
   assign cells_eff = (map_cells_ff > CELLS_LIMIT) ? CELLS_LIMIT : map_cells_ff;
   assign thr       = cells_eff >> 1;
   assign latch     = walk_end && end_tok.done && end_tok.hit
                      && (end_tok.count > thr) && !floor_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (walk_start) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (walk_end) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Floor, overflow and result beat
   always_comb begin
      floor_valid_in = floor_valid_ff;
      floor_level_in = floor_level_ff;
      overflow_in    = overflow_ff;
      if (tbl_clear) begin
         overflow_in = 1'b0;
      end
      if (walk_end && !end_tok.done) begin
         overflow_in = 1'b1;
      end
      if (latch) begin
         floor_valid_in = 1'b1;
         floor_level_in = end_tok.depth;
      end

      load         = (accept && !walk_start) || walk_end;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      blocked_in   = blocked_ff;
      found_in     = found_ff;
      fdepth_in    = fdepth_ff;
      ovf_in       = ovf_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         blocked_in   = accept && !is_tally
                        && ((req_depth == FAR_DEPTH)
                            || (floor_valid_ff && (req_depth < floor_level_ff)));
         found_in     = floor_valid_in;
         fdepth_in    = floor_level_in;
         ovf_in       = overflow_in;
      end

      inj_in       = '0;
      inj_in.live  = walk_start;
      inj_in.depth = req_depth;
   end

   // Register reads and writes
   assign reg_idx   = reg_idx_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      map_cells_in = map_cells_ff;
      prdata       = '0;
      unique case (reg_idx)
         REG_MAP_CELLS: begin
            prdata = CSR_DATA_W'(map_cells_ff);
            if (csr_write) map_cells_in = pwdata[CELLS_W-1:0];
         end
         default: prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         map_cells_ff   <= MAP_CELLS_RESET;
         floor_valid_ff <= 1'b0;
         floor_level_ff <= '0;
         overflow_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         inj_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         map_cells_ff   <= map_cells_in;
         floor_valid_ff <= floor_valid_in;
         floor_level_ff <= floor_level_in;
         overflow_ff    <= overflow_in;
         rsp_valid_ff   <= rsp_valid_in;
         inj_ff         <= inj_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      blocked_ff <= blocked_in;
      found_ff   <= found_in;
      fdepth_ff  <= fdepth_in;
      ovf_ff     <= ovf_in;
   end

   assign inj_tok            = inj_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_blocked        = blocked_ff;
   assign rsp_floor_found    = found_ff;
   assign rsp_floor_depth    = fdepth_ff;
   assign rsp_table_overflow = ovf_ff;

`ifndef NO_ASSERTIONS
   // once latched, the floor stays until reset
   a_floor_sticky: assert property (@(posedge clock) disable iff (reset)
      $fell(floor_valid_ff) |-> $past(reset))
      else $error("floor_valid dropped without reset");

   // no floor level without a latched floor
   a_floor_zero: assert property (@(posedge clock) disable iff (reset)
      !floor_valid_ff |-> (floor_level_ff == '0))
      else $error("floor level set while no floor latched");

   // a token leaves the chain only during a walk
   a_end_in_walk: assert property (@(posedge clock) disable iff (reset)
      end_tok.live |-> (state_ff == ST_WALK))
      else $error("token left chain outside a walk");

   // overflow rises only on a token that found no place
   a_ovf_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(overflow_ff) |-> $past(end_tok.live && !end_tok.done))
      else $error("overflow set without a dropped value");
`endif

endmodule

`default_nettype wire

FILE: hdl/majority_depth_floor_classifier_top.sv
`default_nettype none

// Majority depth floor classifier. A depth map is streamed through twice:
// tally beats (action 0) count distinct depths in a table of TALLY_ENTRIES
// entries, one per cell of a chain, and latch the first repeated depth whose
// count exceeds half the clamped map_cells; classify beats (action 1) report
// a cell blocked when it is the far plane or lies below the latched floor.
// Classify beats, and tally beats once a floor is latched, give their result
// beat from a register, in the cycle after acceptance. A tally beat that
// still searches walks a token down the cell chain one cell per cycle, and
// the next beat is not taken until the token has left the end of the chain.
// One beat is in work at a time. first_of_map on a tally beat empties the
// table in the accepting cycle.

module majority_depth_floor_classifier_top
   import mdfc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // sample channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_action,
   input  wire logic [DEPTH_W-1:0]    req_depth,
   input  wire logic                  req_first_of_map,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_blocked,
   output logic                       rsp_floor_found,
   output logic [DEPTH_W-1:0]         rsp_floor_depth,
   output logic                       rsp_table_overflow,
   // configuration port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   tok_type chain [TALLY_ENTRIES+1];
   logic    tbl_clear;

   // Controller, result register and configuration
   mdfc_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_depth          (req_depth),
      .req_first_of_map   (req_first_of_map),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_blocked        (rsp_blocked),
      .rsp_floor_found    (rsp_floor_found),
      .rsp_floor_depth    (rsp_floor_depth),
      .rsp_table_overflow (rsp_table_overflow),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready),
      .inj_tok            (chain[0]),
      .tbl_clear          (tbl_clear),
      .end_tok            (chain[TALLY_ENTRIES])
   );

   // Chain of table cells
   for (genvar g = 0; g < TALLY_ENTRIES; g++) begin : g_cell
      mdfc_cell u_cell (
         .clock (clock),
         .reset (reset),
         .clear (tbl_clear),
         .tok_i (chain[g]),
         .tok_o (chain[g+1])
      );
   end

endmodule

`default_nettype wire

FILE: test/majority_depth_floor_classifier_checker.sv
`timescale 1ns / 1ps

module majority_depth_floor_classifier_checker
   import mdfc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic                  req_action,
   input  wire logic [DEPTH_W-1:0]    req_depth,
   input  wire logic                  req_first_of_map,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire logic                  rsp_blocked,
   input  wire logic                  rsp_floor_found,
   input  wire logic [DEPTH_W-1:0]    rsp_floor_depth,
   input  wire logic                  rsp_table_overflow,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   input  wire logic [CSR_DATA_W-1:0] prdata,
   input  wire logic                  pready,
   output int                         mismatch_count,
   output int                         outstanding
);

   localparam logic [CSR_ADDR_W-1:0] MAP_CELLS_ADDR = CSR_ADDR_W'(4 * REG_MAP_CELLS);

   typedef struct packed {
      logic               blocked;
      logic               floor_found;
      logic [DEPTH_W-1:0] floor_depth;
      logic               table_overflow;
   } cell_verdict_type;

   // shadow of the depth tally and the floor search
   logic [DEPTH_W-1:0] seen_depth [TALLY_ENTRIES];
   logic [COUNT_W-1:0] seen_count [TALLY_ENTRIES];
   int                 seen_used;
   logic [DEPTH_W-1:0] floor_level;
   logic               floor_locked;
   logic               dropped_new;
   logic [CELLS_W-1:0] cells_reg;
   cell_verdict_type   expected_cells [$];

   function automatic void clear_tally();
      for (int i = 0; i < TALLY_ENTRIES; i++) seen_count[i] = '0;
      seen_used   = 0;
      dropped_new = 1'b0;
   endfunction

   // count one depth; a repeat past half the clamped cell count locks the floor
   function automatic void count_depth(logic [DEPTH_W-1:0] d);
      logic [CELLS_W-1:0] eff_cells;
      logic [COUNT_W-1:0] c;
      eff_cells = (cells_reg > CELLS_LIMIT) ? CELLS_LIMIT : cells_reg;
      for (int i = 0; i < seen_used; i++) begin
         if (seen_depth[i] == d) begin
            c = seen_count[i];
            if (c != COUNT_MAX) c = c + COUNT_ONE;
            seen_count[i] = c;
            if (c > (eff_cells >> 1) && !floor_locked) begin
               floor_level  = d;
               floor_locked = 1'b1;
            end
            return;
         end
      end
      // first appearance: enter it, or flag the drop when the table is full
      if (seen_used < TALLY_ENTRIES) begin
         seen_depth[seen_used] = d;
         seen_count[seen_used] = COUNT_ONE;
         seen_used++;
      end else begin
         dropped_new = 1'b1;
      end
   endfunction

   function automatic cell_verdict_type judge_cell(action_type act, logic [DEPTH_W-1:0] d,
                                                   logic map_start);
      cell_verdict_type v;
      v.blocked = 1'b0;
      if (act == ACT_TALLY) begin
         if (map_start) clear_tally();
         if (!floor_locked) count_depth(d);
      end else begin
         v.blocked = (d == FAR_DEPTH) || (floor_locked && d < floor_level);
      end
      v.floor_found    = floor_locked;
      v.floor_depth    = floor_locked ? floor_level : '0;
      v.table_overflow = dropped_new;
      return v;
   endfunction

   function automatic void check_field(string name, logic [CSR_DATA_W-1:0] want,
                                       logic [CSR_DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      cell_verdict_type want;
      if (reset) begin
         clear_tally();
         floor_level  = '0;
         floor_locked = 1'b0;
         cells_reg    = MAP_CELLS_RESET;
         expected_cells.delete();
         mismatch_count = 0;
      end else begin
         // register port: track writes, check readback
         if (psel && penable && pready && paddr == MAP_CELLS_ADDR) begin
            if (pwrite) cells_reg = pwdata[CELLS_W-1:0];
            else check_field("map_cells readback", CSR_DATA_W'(cells_reg), prdata);
         end

         // result beat against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (expected_cells.size() == 0) begin
               $error("result beat with no sample outstanding");
               mismatch_count++;
            end else begin
               want = expected_cells.pop_front();
               check_field("blocked", CSR_DATA_W'(want.blocked), CSR_DATA_W'(rsp_blocked));
               check_field("floor_found", CSR_DATA_W'(want.floor_found),
                           CSR_DATA_W'(rsp_floor_found));
               check_field("floor_depth", CSR_DATA_W'(want.floor_depth),
                           CSR_DATA_W'(rsp_floor_depth));
               check_field("table_overflow", CSR_DATA_W'(want.table_overflow),
                           CSR_DATA_W'(rsp_table_overflow));
            end
         end

         // sample beat
         if (req_valid && !req_stall)
            expected_cells.insert(expected_cells.size(),
                                  judge_cell(action_type'(req_action), req_depth,
                                             req_first_of_map));
      end
      outstanding <= expected_cells.size();
   end

endmodule

FILE: test/majority_depth_floor_classifier_top_test.sv
`timescale 1ns / 1ps

module majority_depth_floor_classifier_top_test
   import mdfc_pkg::*;
;

   localparam logic [CSR_ADDR_W-1:0] MAP_CELLS_ADDR = CSR_ADDR_W'(4 * REG_MAP_CELLS);
   localparam int WALK_SETTLE = TALLY_ENTRIES + 16;
   localparam int HOLD_CYCLES = 400;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_action;
   logic [DEPTH_W-1:0]    req_depth;
   logic                  req_first_of_map;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_blocked;
   logic                  rsp_floor_found;
   logic [DEPTH_W-1:0]    rsp_floor_depth;
   logic                  rsp_table_overflow;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    mismatch_count;
   int                    outstanding;

   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   bit          hold_request       = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   majority_depth_floor_classifier_top u_top (
      .clock, .reset,
      .req_valid, .req_stall, .req_action, .req_depth, .req_first_of_map,
      .rsp_valid, .rsp_stall, .rsp_blocked, .rsp_floor_found, .rsp_floor_depth,
      .rsp_table_overflow,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   majority_depth_floor_classifier_checker u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_action, .req_depth, .req_first_of_map,
      .rsp_valid, .rsp_stall, .rsp_blocked, .rsp_floor_found, .rsp_floor_depth,
      .rsp_table_overflow,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
      .mismatch_count, .outstanding
   );

   // result side: random stalls, plus a long hold-off on request
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // offer one sample beat, leave valid high once it is taken
   task automatic send_beat(input action_type act, input logic [DEPTH_W-1:0] d,
                            input logic map_start);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_depth        <= d;
      req_first_of_map <= map_start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic csr_cycle(input logic wr, input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= MAP_CELLS_ADDR;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // change the cell count only with the block quiet; read it back
   task automatic program_cells(input logic [CELLS_W-1:0] value);
      drain_results();
      repeat (WALK_SETTLE) @(posedge clock);
      csr_cycle(1'b1, CSR_DATA_W'(value));
      csr_cycle(1'b0, '0);
   endtask

   // depth near an anchor, at an extreme, or anywhere
   function automatic logic [DEPTH_W-1:0] pick_depth(input logic [DEPTH_W-1:0] anchor);
      case ($urandom_range(7))
         0:       return '0;
         1:       return FAR_DEPTH;
         2:       return FAR_DEPTH - DEPTH_W'(1);
         3, 4:    return anchor + DEPTH_W'($urandom_range(4)) - DEPTH_W'(2);
         5:       return anchor;
         default: return DEPTH_W'($urandom);
      endcase
   endfunction

   // one map: tally pass then classify pass over the same cells
   task automatic run_map(input logic [DEPTH_W-1:0] anchor, input int unsigned len);
      logic [DEPTH_W-1:0] alphabet   [6];
      logic [DEPTH_W-1:0] cell_depth [32];
      int unsigned        kinds;
      kinds = $urandom_range(6, 1);
      for (int i = 0; i < kinds; i++) alphabet[i] = pick_depth(anchor);
      for (int i = 0; i < len; i++) cell_depth[i] = alphabet[$urandom_range(kinds - 1)];
      // map start on the first beat, stray clears now and then
      for (int i = 0; i < len; i++)
         send_beat(ACT_TALLY, cell_depth[i], (i == 0) || ($urandom_range(24) == 0));
      for (int i = 0; i < len; i++)
         send_beat(ACT_CLASSIFY, ($urandom_range(9) == 0) ? pick_depth(anchor) : cell_depth[i],
                   1'($urandom_range(1)));
   endtask

   initial begin
      logic [DEPTH_W-1:0] fill_base;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_action       <= ACT_TALLY;
      req_depth        <= '0;
      req_first_of_map <= 1'b0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes under the reset cell count, no floor yet
      send_beat(ACT_CLASSIFY, '0, 1'b1);            // map start ignored on classify
      send_beat(ACT_CLASSIFY, FAR_DEPTH, 1'b0);
      send_beat(ACT_CLASSIFY, FAR_DEPTH - DEPTH_W'(1), 1'b0);
      send_beat(ACT_TALLY, '0, 1'b1);
      send_beat(ACT_TALLY, '0, 1'b0);               // repeat, far under threshold
      send_beat(ACT_TALLY, FAR_DEPTH, 1'b0);
      send_beat(ACT_TALLY, FAR_DEPTH, 1'b0);
      send_beat(ACT_TALLY, 24'h5A5A5A, 1'b0);
      send_beat(ACT_TALLY, 24'hA5A5A5, 1'b1);       // map start drops earlier counts
      send_beat(ACT_CLASSIFY, 24'h5A5A5A, 1'b0);
      send_beat(ACT_CLASSIFY, 24'h000001, 1'b0);

      // random maps shorter than the threshold, so no floor yet
      program_cells(CELLS_W'($urandom_range(4096, 64)));
      sender_idle_pct = 55;
      repeat (4) run_map(DEPTH_W'($urandom), $urandom_range(24, 4));
      sender_idle_pct    = 0;
      receiver_stall_pct = 55;
      program_cells(CELLS_W'($urandom_range(4096, 64)));
      repeat (4) run_map(DEPTH_W'($urandom), $urandom_range(24, 4));

      // largest cell count (clamped); fill the table and overflow it
      program_cells('1);
      fill_base = DEPTH_W'($urandom_range(24'hE00000, 24'h100000));
      send_beat(ACT_TALLY, fill_base, 1'b1);
      for (int i = 1; i < TALLY_ENTRIES + 4; i++) begin
         send_beat(ACT_TALLY, fill_base + DEPTH_W'(i), 1'b0);
         if (i % 40 == 0) send_beat(ACT_CLASSIFY, pick_depth(fill_base), 1'($urandom_range(1)));
      end
      send_beat(ACT_TALLY, fill_base + DEPTH_W'(3), 1'b0);    // repeat still counts when full

      // zero cells: first repeat locks the floor while overflow is still set
      sender_idle_pct    = 28;
      receiver_stall_pct = 28;
      program_cells('0);
      send_beat(ACT_TALLY, fill_base + DEPTH_W'(TALLY_ENTRIES + 40), 1'b0);
      send_beat(ACT_TALLY, fill_base + DEPTH_W'(7), 1'b0);
      send_beat(ACT_CLASSIFY, fill_base + DEPTH_W'(6), 1'b0); // just below the floor
      send_beat(ACT_CLASSIFY, fill_base + DEPTH_W'(7), 1'b0);
      send_beat(ACT_TALLY, fill_base + DEPTH_W'(9), 1'b0);    // search finished, not counted
      send_beat(ACT_TALLY, fill_base + DEPTH_W'(7), 1'b1);    // map start still clears overflow

      // floor locked: maps around it under each idling mix
      program_cells(CELLS_W'(1));
      repeat (3) run_map(fill_base + DEPTH_W'(7), $urandom_range(24, 4));
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      repeat (2) run_map(fill_base + DEPTH_W'(7), $urandom_range(24, 4));

      // long result hold-off while beats keep coming
      hold_request = 1'b1;
      repeat (2) run_map(fill_base + DEPTH_W'(7), $urandom_range(24, 4));

      program_cells(MAP_CELLS_RESET);
      sender_idle_pct    = 55;
      receiver_stall_pct = 55;
      repeat (2) run_map(fill_base + DEPTH_W'(7), $urandom_range(24, 4));
      sender_idle_pct = 0;
      repeat (2) run_map(fill_base + DEPTH_W'(7), $urandom_range(24, 4));
      program_cells(CELLS_W'($urandom));
      sender_idle_pct    = 28;
      receiver_stall_pct = 28;
      run_map(fill_base + DEPTH_W'(7), $urandom_range(24, 4));

      drain_results();
      repeat (WALK_SETTLE) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // hang guard
   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

FILE: majority_depth_floor_classifier_top.f
hdl/mdfc_pkg.sv
hdl/mdfc_cell.sv
hdl/mdfc_ctrl.sv
hdl/majority_depth_floor_classifier_top.sv
test/majority_depth_floor_classifier_checker.sv
test/majority_depth_floor_classifier_top_test.sv
